>>> rtl/header_footer_byte_deframer_unit_defines.svh
// assertion macros used by the deframer rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef HEADER_FOOTER_BYTE_DEFRAMER_UNIT_DEFINES_SVH
`define HEADER_FOOTER_BYTE_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define HFBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HFBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hfbd_pkg.sv
// types, constants and helper functions of the header/footer byte deframer
// no dependencies; used by hfbd_readout and header_footer_byte_deframer_unit
`default_nettype none

package hfbd_pkg;

  localparam int unsigned BufferDepth  = 64;
  localparam int unsigned MaxMarkerLen = 8;
  localparam int unsigned AddrW        = $clog2(BufferDepth);
  localparam int unsigned CountW       = $clog2(BufferDepth + 1);
  localparam int unsigned LenW         = $clog2(MaxMarkerLen + 1);
  localparam int unsigned RecentW      = 8 * MaxMarkerLen;
  localparam int unsigned MarkerW      = 64;
  localparam int unsigned LenRegW      = 4;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAliveByte   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHeaderBytes = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHeaderLen   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFooterBytes = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFooterLen   = 3'd4;

  typedef enum logic [2:0] {
    EvAlive          = 3'd0,
    EvOverflow       = 3'd1,
    EvHeaderInStream = 3'd2,
    EvFooterNoHeader = 3'd3,
    EvEmpty          = 3'd4,
    EvContent        = 3'd5
  } event_e;

  // one result transaction
  typedef struct packed {
    event_e     evt;
    logic [7:0] data;
    logic       last;
  } item_t;

  // control from the byte side to the readout side
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [7:0]        wdata;
    logic              push_evt;
    event_e            evt;
    logic              start;
    logic [CountW-1:0] count;
  } req_t;

  // 0 acts as 1, anything above the maximum acts as the maximum
  function automatic logic [LenW-1:0] clamp_len(input logic [LenRegW-1:0] len);
    logic [LenW-1:0] res;
    if (len == '0) begin
      res = LenW'(1);
    end else if (32'(len) > MaxMarkerLen) begin
      res = LenW'(MaxMarkerLen);
    end else begin
      res = LenW'(len);
    end
    return res;
  endfunction

  // true when the buffer holds at least len bytes and its tail equals the marker
  function automatic logic ends_with(input logic [RecentW-1:0] recent,
                                     input logic [MarkerW-1:0] marker,
                                     input logic [LenW-1:0]    len,
                                     input logic [CountW-1:0]  fill);
    logic ok;
    ok = (32'(fill) >= 32'(len));
    for (int k = 0; k < MaxMarkerLen; k++) begin
      if ((k < 32'(len)) && (recent[8*k +: 8] != marker[8*k +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> rtl/header_footer_byte_deframer_unit.sv
// Header/footer byte deframer. Bytes arrive on the s_axis channel, one
// transaction per byte. Results leave on the m_axis channel: tuser carries the
// event code, tdata the content byte (zero for other events), tlast marks the
// final result caused by one input byte. Configuration is a plain write port
// (cfg_we_i, cfg_addr_i, cfg_wdata_i); the user must write it only while the
// block is idle, which the block itself does not enforce. Throughput: one
// byte per cycle while m_axis keeps up and no readout is running; single-event
// results go into a two-entry result queue in the cycle the byte is taken and
// are registered there before they reach m_axis. A byte that completes a packet
// starts a readout of the byte store: n content bytes pass through the store's
// registered read port, and s_axis_tready is low during the readout. When the
// receiver stalls, the queue fills and s_axis_tready drops once it holds two
// results or a readout is pending. Reset empties the buffer and queue, leaves
// the stream and restores the register defaults; the byte store is not
// cleared, since only entries written since the last clear are ever read.
// depends on hfbd_pkg and hfbd_readout
`default_nettype none

module header_footer_byte_deframer_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // byte input
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  // result output
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [7:0] content_byte
  output logic [2:0]                         m_axis_tuser,   // [2:0] event_res
  output logic                               m_axis_tlast,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [hfbd_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [hfbd_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [7:0]                      alive_q;
  logic [hfbd_pkg::MarkerW-1:0]    header_q, footer_q;
  logic [hfbd_pkg::LenRegW-1:0]    header_len_q, footer_len_q;

  logic [hfbd_pkg::AddrW-1:0]      fill_q, fill_d;
  logic [hfbd_pkg::RecentW-1:0]    recent_q, recent_d, recent_nx;
  logic                            inpkt_q, inpkt_d;

  logic                            acc, idle;
  logic [hfbd_pkg::CountW-1:0]     fill_inc, content_n;
  logic [hfbd_pkg::LenW-1:0]       hlen, flen;
  logic                            ovf, hmatch, fmatch;
  hfbd_pkg::req_t                  req;
  hfbd_pkg::item_t                 item;

  assign s_axis_tready = idle;
  assign acc           = s_axis_tvalid && idle;

  // marker matching on the buffer after appending this byte
  assign fill_inc  = {1'b0, fill_q} + hfbd_pkg::CountW'(1);
  assign recent_nx = {recent_q[hfbd_pkg::RecentW-9:0], s_axis_tdata};
  assign hlen      = hfbd_pkg::clamp_len(header_len_q);
  assign flen      = hfbd_pkg::clamp_len(footer_len_q);
  assign ovf       = (fill_inc >= hfbd_pkg::CountW'(hfbd_pkg::BufferDepth));
  assign hmatch    = hfbd_pkg::ends_with(recent_nx, header_q, hlen, fill_inc);
  assign fmatch    = hfbd_pkg::ends_with(recent_nx, footer_q, flen, fill_inc);
  assign content_n = fill_inc - hfbd_pkg::CountW'(flen);

  // per-byte decision
  always_comb begin
    fill_d       = fill_q;
    recent_d     = recent_q;
    inpkt_d      = inpkt_q;
    req.we       = 1'b0;
    req.waddr    = fill_q;
    req.wdata    = s_axis_tdata;
    req.push_evt = 1'b0;
    req.evt      = hfbd_pkg::EvAlive;
    req.start    = 1'b0;
    req.count    = content_n;
    if (acc) begin
      if (s_axis_tdata == alive_q) begin
        fill_d       = '0;
        recent_d     = '0;
        inpkt_d      = 1'b0;
        req.push_evt = 1'b1;
        req.evt      = hfbd_pkg::EvAlive;
      end else begin
        req.we   = 1'b1;
        fill_d   = fill_inc[hfbd_pkg::AddrW-1:0];
        recent_d = recent_nx;
        if (ovf) begin
          fill_d       = '0;
          recent_d     = '0;
          inpkt_d      = 1'b0;
          req.push_evt = 1'b1;
          req.evt      = hfbd_pkg::EvOverflow;
        end else if (hmatch) begin
          fill_d       = '0;
          recent_d     = '0;
          inpkt_d      = 1'b1;
          req.push_evt = inpkt_q;
          req.evt      = hfbd_pkg::EvHeaderInStream;
        end else if (fmatch) begin
          fill_d   = '0;
          recent_d = '0;
          if (!inpkt_q) begin
            req.push_evt = 1'b1;
            req.evt      = hfbd_pkg::EvFooterNoHeader;
          end else begin
            inpkt_d = 1'b0;
            if (content_n == '0) begin
              req.push_evt = 1'b1;
              req.evt      = hfbd_pkg::EvEmpty;
            end else begin
              req.start = 1'b1;
            end
          end
        end
      end
    end
  end

  // framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      recent_q <= '0;
      inpkt_q  <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      recent_q <= recent_d;
      inpkt_q  <= inpkt_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q      <= '0;
      header_q     <= '0;
      header_len_q <= hfbd_pkg::LenRegW'(1);
      footer_q     <= '0;
      footer_len_q <= hfbd_pkg::LenRegW'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        hfbd_pkg::CfgAliveByte:   alive_q      <= cfg_wdata_i[7:0];
        hfbd_pkg::CfgHeaderBytes: header_q     <= cfg_wdata_i;
        hfbd_pkg::CfgHeaderLen:   header_len_q <= cfg_wdata_i[hfbd_pkg::LenRegW-1:0];
        hfbd_pkg::CfgFooterBytes: footer_q     <= cfg_wdata_i;
        hfbd_pkg::CfgFooterLen:   footer_len_q <= cfg_wdata_i[hfbd_pkg::LenRegW-1:0];
        default: ;
      endcase
    end
  end

  hfbd_readout u_readout (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .idle_o       (idle),
    .item_o       (item),
    .item_valid_o (m_axis_tvalid),
    .item_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = item.evt;
  assign m_axis_tdata = item.data;
  assign m_axis_tlast = item.last;

endmodule

`default_nettype wire

>>> rtl/hfbd_readout.sv
// byte store memory, content readout sequencer and two-entry result queue
// depends on hfbd_pkg and header_footer_byte_deframer_unit_defines.svh
`default_nettype none
`include "header_footer_byte_deframer_unit_defines.svh"

module hfbd_readout (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hfbd_pkg::req_t req_i,
  output logic                idle_o,
  output hfbd_pkg::item_t     item_o,
  output logic                item_valid_o,
  input  wire logic           item_ready_i
);

  logic [7:0]                     mem [hfbd_pkg::BufferDepth];
  logic [7:0]                     mem_q;
  logic [hfbd_pkg::CountW-1:0]    rd_rem_q, rd_rem_d;
  logic [hfbd_pkg::AddrW-1:0]     rd_addr_q, rd_addr_d;
  logic                           pend_q, pend_d;
  logic                           pend_last_q, pend_last_d;
  hfbd_pkg::item_t                fifo_q [2];
  logic                           wr_ptr_q, rd_ptr_q;
  logic [1:0]                     cnt_q, cnt_d;
  logic [1:0]                     occ;
  logic                           pop, push, issue;
  hfbd_pkg::item_t                push_item;

  // output side of the queue
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign pop          = item_valid_o && item_ready_i;

  // read issue keeps queue plus in-flight read within two entries
  assign occ   = cnt_q + {1'b0, pend_q};
  assign issue = (rd_rem_q != '0) && ((occ < 2'd2) || ((occ == 2'd2) && pop));

  assign idle_o = (rd_rem_q == '0) && !pend_q && (cnt_q != 2'd2);

  // queue push source: returning read data or a single event
  always_comb begin
    push_item.evt  = hfbd_pkg::EvContent;
    push_item.data = mem_q;
    push_item.last = pend_last_q;
    push           = pend_q;
    if (req_i.push_evt) begin
      push_item.evt  = req_i.evt;
      push_item.data = '0;
      push_item.last = 1'b1;
      push           = 1'b1;
    end
  end

  // readout sequencer next state
  always_comb begin
    rd_rem_d    = rd_rem_q;
    rd_addr_d   = rd_addr_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    if (req_i.start) begin
      rd_rem_d  = req_i.count;
      rd_addr_d = '0;
    end else if (issue) begin
      rd_rem_d    = rd_rem_q - hfbd_pkg::CountW'(1);
      rd_addr_d   = rd_addr_q + hfbd_pkg::AddrW'(1);
      pend_d      = 1'b1;
      pend_last_d = (rd_rem_q == hfbd_pkg::CountW'(1));
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_rem_q    <= '0;
      rd_addr_q   <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      rd_rem_q    <= rd_rem_d;
      rd_addr_q   <= rd_addr_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      cnt_q       <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (issue) begin
      mem_q <= mem[rd_addr_q];
    end
  end

  `HFBD_ASSERT_NOW(a_no_queue_overflow, push && !pop, cnt_q != 2'd2, "result queue overflow")
  `HFBD_ASSERT_NOW(a_single_push_source, req_i.push_evt, !pend_q, "event push during readout")
  `HFBD_ASSERT_NOW(a_start_when_idle, req_i.start || req_i.we, (rd_rem_q == '0) && !pend_q,
                   "new byte while readout active")
  `HFBD_ASSERT_NEXT(a_issue_returns, issue, pend_q, "issued read did not return")

endmodule

`default_nettype wire
